// File: hw/rtl/glyph_text_layout_defines.svh
// Assertion macros shared by the glyph text layout RTL.
`ifndef GLYPH_TEXT_LAYOUT_DEFINES_SVH
`define GLYPH_TEXT_LAYOUT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define GTL_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define GTL_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/gtl_pkg.sv
// Types and constants for the glyph text layout block.
`default_nettype none

package gtl_pkg;

    localparam int POS_W  = 9;
    localparam int CODE_W = 9;
    localparam int CFG_W  = 7;
    localparam int CFG_IW = 2;

    localparam logic [CFG_IW-1:0] CFG_START_X = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_START_Y = 2'd1;

    localparam logic [POS_W-1:0]  POS_MAX    = 9'd511;
    localparam logic [CODE_W-1:0] CODE_CLAMP = 9'h11A;
    localparam logic [CODE_W-1:0] CODE_EXT   = 9'h100;
    localparam logic [CODE_W-1:0] CODE_UNDER = 9'h05F;
    localparam logic [CODE_W-1:0] CODE_FF    = 9'h0FF;

    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_VT   = 8'h0B;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_ESC  = 8'hFF;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_FOUR = 8'h34;
    localparam logic [7:0] CH_COLN = 8'h3A;
    localparam logic [7:0] CH_EQU  = 8'h3D;

    localparam int OQ_DEPTH = 2;
    localparam int OQ_AW    = 1;
    localparam int OQ_CW    = 2;
    localparam int RQ_DEPTH = 4;
    localparam int RQ_AW    = 2;
    localparam int RQ_CW    = 3;

    typedef enum logic [2:0] {
        OP_END,
        OP_TAB,
        OP_VT,
        OP_CR,
        OP_ESC,
        OP_GLYPH
    } op_kind_t;

    typedef struct packed {
        op_kind_t          cls;
        logic [7:0]        byte_val;
        logic              esc_ok;
        logic              esc_dbl;
        logic [CODE_W-1:0] code0;
        logic [CODE_W-1:0] code1;
    } op_t;

    typedef struct packed {
        logic              kind;
        logic [CODE_W-1:0] glyph_code;
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
        logic [POS_W-1:0]  widest_x;
        logic              last;
    } res_t;

    typedef struct packed {
        logic [1:0] n;
        res_t       r0;
        res_t       r1;
    } res_pair_t;

    function automatic logic [POS_W-1:0] sat_add(input logic [POS_W-1:0] a,
                                                 input logic [POS_W-1:0] b);
        logic [POS_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[POS_W] ? POS_MAX : s[POS_W-1:0];
    endfunction

    function automatic logic [POS_W-1:0] pos_max(input logic [POS_W-1:0] a,
                                                 input logic [POS_W-1:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic [CODE_W-1:0] clamp_code(input logic [CODE_W-1:0] c);
        return (c >= CODE_CLAMP) ? CODE_UNDER : c;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/gtl_front.sv
// Front end: accepts string bytes, classifies them and queues the ops.
`default_nettype none

module gtl_front
    import gtl_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire logic [7:0] char_byte,
    output logic            full,
    output logic            op_valid,
    output op_t             op,
    input  wire logic       op_take
);

    op_t              slot_reg [OQ_DEPTH];
    logic [OQ_AW-1:0] wp_reg, wp_next;
    logic [OQ_AW-1:0] rp_reg, rp_next;
    logic [OQ_CW-1:0] cnt_reg, cnt_next;

    op_t        cls_op;
    logic [4:0] off;
    logic       push_ok;
    logic       take_ok;

    always_comb
    begin
        off            = 5'(char_byte - CH_ZERO);
        cls_op.byte_val = char_byte;
        cls_op.esc_ok  = (char_byte >= CH_ZERO) && (char_byte <= CH_EQU);
        cls_op.esc_dbl = (char_byte <= CH_FOUR) || (char_byte >= CH_COLN);
        cls_op.code0   = clamp_code(CODE_EXT | {3'b000, off, 1'b0});
        cls_op.code1   = clamp_code(CODE_EXT | {3'b000, off, 1'b1});
        case (char_byte)
            CH_NUL:  cls_op.cls = OP_END;
            CH_TAB:  cls_op.cls = OP_TAB;
            CH_VT:   cls_op.cls = OP_VT;
            CH_CR:   cls_op.cls = OP_CR;
            CH_ESC:  cls_op.cls = OP_ESC;
            default: cls_op.cls = OP_GLYPH;
        endcase
    end

    assign full     = (cnt_reg == OQ_CW'(OQ_DEPTH));
    assign op_valid = (cnt_reg != '0);
    assign op       = slot_reg[rp_reg];
    assign push_ok  = push && !full;
    assign take_ok  = op_take && op_valid;

    always_comb
    begin
        wp_next  = wp_reg + OQ_AW'(push_ok);
        rp_next  = rp_reg + OQ_AW'(take_ok);
        cnt_next = cnt_reg + OQ_CW'(push_ok) - OQ_CW'(take_ok);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            slot_reg[wp_reg] <= cls_op;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/gtl_back.sv
// Back end: cursor state, escape handling and result generation.
`default_nettype none
`include "glyph_text_layout_defines.svh"

module gtl_back
    import gtl_pkg::*;
#(
    parameter int AREA_WIDTH       = 128,
    parameter int AREA_HEIGHT      = 128,
    parameter int HALF_CELL_WIDTH  = 8,
    parameter int HALF_CELL_HEIGHT = 16
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [CFG_IW-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_data,
    input  wire logic              op_valid,
    input  wire op_t               op,
    output logic                   op_take,
    input  wire logic              room,
    output res_pair_t              res
);

    localparam int YLIM_I = AREA_HEIGHT - 2 * HALF_CELL_HEIGHT;
    localparam bit Y_CHECK = (YLIM_I >= 0);
    localparam logic [POS_W-1:0] XLIM      = POS_W'(AREA_WIDTH - 2 * HALF_CELL_WIDTH);
    localparam logic [POS_W-1:0] YLIM      = POS_W'(Y_CHECK ? YLIM_I : 0);
    localparam logic [POS_W-1:0] TAB_STEP  = POS_W'(HALF_CELL_WIDTH);
    localparam logic [POS_W-1:0] CELL_STEP = POS_W'(2 * HALF_CELL_WIDTH);
    localparam logic [POS_W-1:0] HALF_ROW  = POS_W'(HALF_CELL_HEIGHT);
    localparam logic [POS_W-1:0] FULL_ROW  = POS_W'(2 * HALF_CELL_HEIGHT);

    logic [CFG_W-1:0] start_x_reg, start_x_next;
    logic [CFG_W-1:0] start_y_reg, start_y_next;
    logic [POS_W-1:0] cx_reg, cx_next;
    logic [POS_W-1:0] cy_reg, cy_next;
    logic [POS_W-1:0] wide_reg, wide_next;
    logic             esc_reg, esc_next;
    logic             halted_reg, halted_next;

    logic [POS_W-1:0] sx;
    logic [POS_W-1:0] x1;
    logic [POS_W-1:0] y1;
    logic             fire;

    function automatic logic y_over(input logic [POS_W-1:0] y);
        return Y_CHECK && (y > YLIM);
    endfunction

    function automatic res_t mk_draw(input logic [CODE_W-1:0] c,
                                     input logic [POS_W-1:0] x,
                                     input logic [POS_W-1:0] y);
        res_t r;
        r            = '0;
        r.glyph_code = c;
        r.pos_x      = x;
        r.pos_y      = y;
        return r;
    endfunction

    function automatic res_t mk_end(input logic [POS_W-1:0] w);
        res_t r;
        r          = '0;
        r.kind     = 1'b1;
        r.widest_x = w;
        return r;
    endfunction

    assign fire    = op_valid && room;
    assign op_take = fire;
    assign sx      = {{(POS_W-CFG_W){1'b0}}, start_x_reg};

    always_comb
    begin
        start_x_next = start_x_reg;
        start_y_next = start_y_reg;
        cx_next      = cx_reg;
        cy_next      = cy_reg;
        wide_next    = wide_reg;
        esc_next     = esc_reg;
        halted_next  = halted_reg;
        res          = '0;
        x1           = sat_add(cx_reg, CELL_STEP);
        y1           = sat_add(cy_reg, FULL_ROW);

        if (fire)
        begin
            if (esc_reg)
            begin
                esc_next = 1'b0;
                if (op.cls == OP_END)
                begin
                    res.n  = 2'd2;
                    res.r0 = mk_draw(CODE_FF, cx_reg, cy_reg);
                    res.r1 = mk_end(pos_max(wide_reg, x1));
                    cx_next     = sx;
                    cy_next     = {{(POS_W-CFG_W){1'b0}}, start_y_reg};
                    wide_next   = sx;
                    halted_next = 1'b0;
                end
                else if (op.esc_ok)
                begin
                    res.n   = 2'd1;
                    res.r0  = mk_draw(op.code0, cx_reg, cy_reg);
                    cx_next = x1;
                    if (op.esc_dbl)
                    begin
                        if (x1 > XLIM)
                        begin
                            cy_next   = y1;
                            wide_next = pos_max(wide_reg, x1);
                            cx_next   = sx;
                        end
                        else
                        begin
                            res.n   = 2'd2;
                            res.r1  = mk_draw(op.code1, x1, cy_reg);
                            cx_next = sat_add(x1, CELL_STEP);
                        end
                    end
                end
            end
            else if (op.cls == OP_END)
            begin
                res.n       = 2'd1;
                res.r0      = mk_end(pos_max(wide_reg, cx_reg));
                cx_next     = sx;
                cy_next     = {{(POS_W-CFG_W){1'b0}}, start_y_reg};
                wide_next   = sx;
                halted_next = 1'b0;
            end
            else if (!halted_reg)
            begin
                case (op.cls)
                    OP_TAB:
                    begin
                        cx_next = sat_add(cx_reg, TAB_STEP);
                    end
                    OP_VT:
                    begin
                        cy_next   = sat_add(cy_reg, HALF_ROW);
                        wide_next = pos_max(wide_reg, cx_reg);
                        cx_next   = sx;
                    end
                    OP_CR:
                    begin
                        cy_next   = y1;
                        wide_next = pos_max(wide_reg, cx_reg);
                        cx_next   = sx;
                    end
                    OP_ESC, OP_GLYPH:
                    begin
                        if (y_over(cy_reg))
                        begin
                            halted_next = 1'b1;
                        end
                        else
                        begin
                            if (cx_reg > XLIM)
                            begin
                                cy_next   = y1;
                                wide_next = pos_max(wide_reg, cx_reg);
                                cx_next   = sx;
                                if (y_over(y1) || (sx > XLIM))
                                begin
                                    halted_next = 1'b1;
                                end
                            end
                            if (!halted_next)
                            begin
                                if (op.cls == OP_ESC)
                                begin
                                    esc_next = 1'b1;
                                end
                                else
                                begin
                                    res.n  = 2'd1;
                                    res.r0 = mk_draw({1'b0, op.byte_val}, cx_next,
                                                     cy_next);
                                    cx_next = sat_add(cx_next, CELL_STEP);
                                end
                            end
                        end
                    end
                    default:
                    begin
                        halted_next = halted_reg;
                    end
                endcase
            end
        end

        if (res.n == 2'd2)
        begin
            res.r1.last = 1'b1;
        end
        else if (res.n == 2'd1)
        begin
            res.r0.last = 1'b1;
        end

        if (cfg_we && ((cfg_index == CFG_START_X) || (cfg_index == CFG_START_Y)))
        begin
            if (cfg_index == CFG_START_X)
            begin
                start_x_next = cfg_data;
            end
            else
            begin
                start_y_next = cfg_data;
            end
            cx_next     = {{(POS_W-CFG_W){1'b0}}, start_x_next};
            cy_next     = {{(POS_W-CFG_W){1'b0}}, start_y_next};
            wide_next   = {{(POS_W-CFG_W){1'b0}}, start_x_next};
            esc_next    = 1'b0;
            halted_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_x_reg <= '0;
            start_y_reg <= '0;
            cx_reg      <= '0;
            cy_reg      <= '0;
            wide_reg    <= '0;
            esc_reg     <= 1'b0;
            halted_reg  <= 1'b0;
        end
        else
        begin
            start_x_reg <= start_x_next;
            start_y_reg <= start_y_next;
            cx_reg      <= cx_next;
            cy_reg      <= cy_next;
            wide_reg    <= wide_next;
            esc_reg     <= esc_next;
            halted_reg  <= halted_next;
        end
    end

    `GTL_ASSERT_IMP(a_esc_not_halted, esc_reg, !halted_reg, "escape pending while halted")
    `GTL_ASSERT_IMP(a_end_emits, fire && (op.cls == OP_END), res.n != 2'd0,
                    "terminator produced no result")
    `GTL_ASSERT_NXT(a_cfg_restart, cfg_we && (cfg_index == CFG_START_X),
                    (cx_reg == sx) && (wide_reg == sx) && !esc_reg && !halted_reg,
                    "start_x write did not restart layout")

endmodule

`default_nettype wire

// File: hw/rtl/gtl_out_fifo.sv
// Result queue: takes up to two beats per cycle, hands out one.
`default_nettype none
`include "glyph_text_layout_defines.svh"

module gtl_out_fifo
    import gtl_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire res_pair_t wr,
    output logic           room,
    output logic           empty,
    input  wire logic      pop,
    output res_t           head
);

    res_t             entry_reg [RQ_DEPTH];
    logic [RQ_AW-1:0] wp_reg, wp_next;
    logic [RQ_AW-1:0] rp_reg, rp_next;
    logic [RQ_CW-1:0] cnt_reg, cnt_next;
    logic             pop_ok;
    logic [RQ_AW-1:0] wp1;

    assign empty  = (cnt_reg == '0);
    assign room   = (cnt_reg <= RQ_CW'(RQ_DEPTH - 2));
    assign head   = entry_reg[rp_reg];
    assign pop_ok = pop && !empty;
    assign wp1    = wp_reg + RQ_AW'(1);

    always_comb
    begin
        wp_next  = wp_reg + RQ_AW'(wr.n);
        rp_next  = rp_reg + RQ_AW'(pop_ok);
        cnt_next = cnt_reg + RQ_CW'(wr.n) - RQ_CW'(pop_ok);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.n != 2'd0)
        begin
            entry_reg[wp_reg] <= wr.r0;
        end
        if (wr.n == 2'd2)
        begin
            entry_reg[wp1] <= wr.r1;
        end
    end

    `GTL_ASSERT_IMP(a_wr_room, wr.n != 2'd0, cnt_reg <= RQ_CW'(RQ_DEPTH - 2),
                    "result write without room")
    `GTL_ASSERT_IMP(a_pair_last, wr.n == 2'd2, wr.r1.last && !wr.r0.last,
                    "two-beat write with wrong last marking")

endmodule

`default_nettype wire

// File: hw/rtl/glyph_text_layout.sv
// A byte is registered in the front-end op queue; the back end then writes its results into
// the result queue, whose head drives the ports. Throughput: one byte per cycle while the
// result queue has room; the result side moves one beat per cycle, set by the single read
// port of the result queue. Control bytes and dropped bytes give no beat.
// Reset: asynchronous, active low; start_x/start_y and the layout clear to zero at once.
`default_nettype none

module glyph_text_layout
    import gtl_pkg::*;
#(
    parameter int AREA_WIDTH       = 128,
    parameter int AREA_HEIGHT      = 128,
    parameter int HALF_CELL_WIDTH  = 8,
    parameter int HALF_CELL_HEIGHT = 16
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [CFG_IW-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_data,
    input  wire logic              push,
    output logic                   full,
    input  wire logic [7:0]        char_byte,
    output logic                   empty,
    input  wire logic              pop,
    output logic                   kind,
    output logic [CODE_W-1:0]      glyph_code,
    output logic [POS_W-1:0]       pos_x,
    output logic [POS_W-1:0]       pos_y,
    output logic [POS_W-1:0]       widest_x,
    output logic                   last
);

    logic      op_valid;
    op_t       op;
    logic      op_take;
    logic      room;
    res_pair_t res;
    res_t      head;

    gtl_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .char_byte (char_byte),
        .full      (full),
        .op_valid  (op_valid),
        .op        (op),
        .op_take   (op_take)
    );

    gtl_back #(
        .AREA_WIDTH       (AREA_WIDTH),
        .AREA_HEIGHT      (AREA_HEIGHT),
        .HALF_CELL_WIDTH  (HALF_CELL_WIDTH),
        .HALF_CELL_HEIGHT (HALF_CELL_HEIGHT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .op_valid  (op_valid),
        .op        (op),
        .op_take   (op_take),
        .room      (room),
        .res       (res)
    );

    gtl_out_fifo u_out (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (res),
        .room  (room),
        .empty (empty),
        .pop   (pop),
        .head  (head)
    );

    assign kind       = head.kind;
    assign glyph_code = head.glyph_code;
    assign pos_x      = head.pos_x;
    assign pos_y      = head.pos_y;
    assign widest_x   = head.widest_x;
    assign last       = head.last;

endmodule

`default_nettype wire
